### sv/lwbkv_pkg.sv
// Package for the LRU write-back key-value cache: item kinds, result actions,
// reply status codes and the controller state type. No dependencies.
`default_nettype none
package lwbkv_pkg;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_FILL  = 2'd3;

    localparam logic [1:0] ACT_REPLY = 2'd0;
    localparam logic [1:0] ACT_WB    = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EVICT,
        S_FLUSH_RD,
        S_FLUSH_CHK,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

### sv/lru_write_back_kv_cache.sv
// LRU write-back key-value cache, top level.
//
// Usage: items enter on the s_axis channel. tdata holds {fill_ok, write_value, key}
// from the lowest bit up (key first); tuser holds kind. Results leave on m_axis:
// tdata holds {out_value, out_key}, tuser holds {status, action}, tlast marks the
// final result of an item. The capacity register sits at APB byte address 0.
// One item is worked at a time. A set, get or fill passes through the key
// lookup (S_LOOK compares all tags and reads the value store, S_EVICT uses the
// read data) before its first result is loaded; an evicted dirty entry is sent
// as a write-back first, and the final reply follows from S_OUT. A flush walks
// the recency list one entry at a time (store read, then check). Each result
// is held in an output register until taken; while m_axis_tready is low the
// controller waits. Reset empties the cache, clears the dirty marks and the
// pending fetch and sets capacity to 16; key and value stores are not cleared.
// Keys and values live in synchronous single-read memories; the recency order,
// dirty marks and a copy of the keys for parallel compare are in flip-flops.
// A busy reply or a failed fill is given straight from S_LOOK, without the
// S_EVICT step.
`default_nettype none
module lru_write_back_kv_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // key[63:0], write_value[127:64], fill_ok[128], zero pad
    input  wire logic [135:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_key[63:0], out_value[127:64]
    output logic [127:0]     m_axis_tdata,
    // action[1:0], status[3:2]
    output logic [3:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // capacity register
    logic [4:0] r_cap;
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {27'd0, r_cap} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 5'd16;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            r_cap <= pwdata[4:0];
        end
    end
    logic [CW-1:0] eff_cap;
    always_comb begin
        if (r_cap == 5'd0) eff_cap = CW'(1);
        else if (32'(r_cap) > ENTRIES) eff_cap = CW'(ENTRIES);
        else eff_cap = CW'(r_cap);
    end

    // key and value memories
    logic [KEY_BITS-1:0]   mem_key [ENTRIES];
    logic [VALUE_BITS-1:0] mem_val [ENTRIES];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [IW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_val[wr_addr] <= wr_val;
        end
        r_rd_key <= mem_key[rd_addr];
        r_rd_val <= mem_val[rd_addr];
    end

    // tag copy for the parallel compare
    logic [KEY_BITS-1:0] r_tag [ENTRIES];
    always_ff @(posedge i_clk) begin
        if (wr_en) r_tag[wr_addr] <= wr_key;
    end

    // control state
    lwbkv_pkg::t_state r_st, n_st;
    logic [IW-1:0]  r_rank [ENTRIES];
    logic [ENTRIES-1:0] r_dirty;
    logic [CW-1:0]  r_cnt;
    logic           r_pend;
    logic [KEY_BITS-1:0]   r_pkey;
    logic [1:0]     r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic           r_ok;
    logic [CW-1:0]  r_pos;       // flush walk / hit position
    logic           r_hit;
    // output register
    logic           r_ov;
    logic [1:0]     r_oact, r_ost;
    logic [KEY_BITS-1:0]   r_okey;
    logic [VALUE_BITS-1:0] r_oval;
    logic           r_olast;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {64'(r_oval), 64'(r_okey)};
    assign m_axis_tuser  = {r_ost, r_oact};
    assign m_axis_tlast  = r_olast;
    assign s_axis_tready = (r_st == lwbkv_pkg::S_IDLE) && !r_ov;

    wire in_acc = s_axis_tvalid && s_axis_tready;

    // hit search over positions below the count
    logic           hit;
    logic [IW-1:0]  hit_pos;
    always_comb begin
        hit = 1'b0;
        hit_pos = '0;
        for (int p = ENTRIES - 1; p >= 0; p--) begin
            if (CW'(p) < r_cnt && r_tag[r_rank[p]] == r_key) begin
                hit = 1'b1;
                hit_pos = IW'(p);
            end
        end
    end

    // insert position: evict last when full
    logic full;
    logic [IW-1:0] ins_pos;
    assign full = r_cnt >= eff_cap;
    assign ins_pos = full ? IW'(r_cnt - CW'(1)) : IW'(r_cnt);

    logic [IW-1:0] flush_slot;
    assign flush_slot = r_rank[r_pos[IW-1:0]];

    // sequencer outputs
    logic do_promote;
    logic [IW-1:0] prom_pos;
    logic do_emit;
    logic [1:0] e_act, e_st;
    logic [KEY_BITS-1:0] e_key;
    logic [VALUE_BITS-1:0] e_val;
    logic e_last;
    lwbkv_pkg::t_state e_after;

    always_comb begin
        n_st = r_st;
        rd_addr = r_rank[ins_pos];
        wr_en = 1'b0;
        wr_addr = r_rank[ins_pos];
        wr_key = r_key;
        wr_val = r_val;
        do_promote = 1'b0;
        prom_pos = ins_pos;
        do_emit = 1'b0;
        e_act = lwbkv_pkg::ACT_REPLY;
        e_st = lwbkv_pkg::ST_OK;
        e_key = r_key;
        e_val = '0;
        e_last = 1'b1;
        e_after = lwbkv_pkg::S_IDLE;
        case (r_st)
            lwbkv_pkg::S_IDLE: begin
                if (in_acc) n_st = lwbkv_pkg::S_LOOK;
            end
            lwbkv_pkg::S_LOOK: begin
                // tag compare done; value read for hit or victim
                if (r_kind == lwbkv_pkg::KIND_FILL) begin
                    if (!r_pend) begin
                        n_st = lwbkv_pkg::S_IDLE;
                    end else if (!r_ok) begin
                        do_emit = 1'b1; e_key = r_pkey; e_st = lwbkv_pkg::ST_FAIL;
                    end else begin
                        rd_addr = r_rank[ins_pos];
                        n_st = lwbkv_pkg::S_EVICT;
                    end
                end else if (r_pend) begin
                    do_emit = 1'b1; e_st = lwbkv_pkg::ST_BUSY;
                end else if (r_kind == lwbkv_pkg::KIND_FLUSH) begin
                    n_st = lwbkv_pkg::S_FLUSH_RD;
                end else begin
                    rd_addr = hit ? r_rank[hit_pos] : r_rank[ins_pos];
                    n_st = lwbkv_pkg::S_EVICT;
                end
            end
            lwbkv_pkg::S_EVICT: begin
                // read data valid; hit info registered
                if (r_kind == lwbkv_pkg::KIND_GET && r_hit) begin
                    do_promote = 1'b1; prom_pos = r_pos[IW-1:0];
                    do_emit = 1'b1; e_val = r_rd_val;
                end else if (r_kind == lwbkv_pkg::KIND_GET) begin
                    do_emit = 1'b1; e_act = lwbkv_pkg::ACT_FETCH;
                end else if (r_kind == lwbkv_pkg::KIND_SET && r_hit) begin
                    wr_en = 1'b1; wr_addr = r_rank[r_pos[IW-1:0]];
                    do_promote = 1'b1; prom_pos = r_pos[IW-1:0];
                    do_emit = 1'b1;
                end else begin
                    // insert (set miss or good fill)
                    wr_en = 1'b1;
                    if (r_kind == lwbkv_pkg::KIND_FILL) begin
                        wr_key = r_pkey; e_key = r_pkey; e_val = r_val;
                    end
                    do_promote = 1'b1;
                    if (full && r_dirty[r_rank[ins_pos]]) begin
                        do_emit = 1'b1; e_act = lwbkv_pkg::ACT_WB;
                        e_key = r_rd_key; e_val = r_rd_val; e_last = 1'b0;
                        e_after = lwbkv_pkg::S_OUT;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
            end
            lwbkv_pkg::S_OUT: begin
                // final reply after a write-back
                do_emit = 1'b1;
                if (r_kind == lwbkv_pkg::KIND_FILL) begin
                    e_key = r_pkey; e_val = r_val;
                end
            end
            lwbkv_pkg::S_FLUSH_RD: begin
                if (r_pos >= r_cnt) begin
                    do_emit = 1'b1; e_key = '0;
                end else begin
                    rd_addr = flush_slot;
                    n_st = lwbkv_pkg::S_FLUSH_CHK;
                end
            end
            lwbkv_pkg::S_FLUSH_CHK: begin
                // keep reading the same slot so the data holds over a stall
                rd_addr = flush_slot;
                if (r_dirty[flush_slot]) begin
                    do_emit = 1'b1; e_act = lwbkv_pkg::ACT_WB;
                    e_key = r_rd_key; e_val = r_rd_val; e_last = 1'b0;
                    e_after = lwbkv_pkg::S_FLUSH_RD;
                end else begin
                    n_st = lwbkv_pkg::S_FLUSH_RD;
                end
            end
            default: n_st = lwbkv_pkg::S_IDLE;
        endcase
        // emitting waits for a free output register
        if (do_emit) begin
            if (r_ov) begin
                do_emit = 1'b0; do_promote = 1'b0; wr_en = 1'b0;
                n_st = r_st;
            end else begin
                n_st = e_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lwbkv_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_dirty <= '0;
            r_cnt <= '0;
            r_pend <= 1'b0;
            r_pkey <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= IW'(i);
        end else begin
            r_st <= n_st;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (in_acc) begin
                r_kind <= s_axis_tuser;
                r_key <= s_axis_tdata[KEY_BITS-1:0];
                r_val <= s_axis_tdata[64 +: VALUE_BITS];
                r_ok <= s_axis_tdata[128];
                r_pos <= '0;
            end
            // a flush walk always starts at the most recent entry
            if (r_st == lwbkv_pkg::S_LOOK) begin
                r_hit <= hit;
                r_pos <= (hit && r_kind != lwbkv_pkg::KIND_FLUSH) ? CW'(hit_pos) : '0;
            end
            if (do_emit) begin
                r_ov <= 1'b1;
                r_oact <= e_act; r_ost <= e_st;
                r_okey <= e_key; r_oval <= e_val;
                r_olast <= e_last;
                // pending fetch bookkeeping
                if (r_st == lwbkv_pkg::S_LOOK && r_kind == lwbkv_pkg::KIND_FILL)
                    r_pend <= 1'b0;
                if (r_st == lwbkv_pkg::S_EVICT && r_kind == lwbkv_pkg::KIND_GET
                        && !r_hit) begin
                    r_pend <= 1'b1; r_pkey <= r_key;
                end
                if (r_st == lwbkv_pkg::S_EVICT && r_kind == lwbkv_pkg::KIND_FILL)
                    r_pend <= 1'b0;
                if (r_st == lwbkv_pkg::S_FLUSH_CHK) begin
                    r_dirty[flush_slot] <= 1'b0;
                    r_pos <= r_pos + CW'(1);
                end
            end
            if (r_st == lwbkv_pkg::S_FLUSH_CHK && !r_dirty[flush_slot])
                r_pos <= r_pos + CW'(1);
            if (wr_en) begin
                r_dirty[wr_addr] <= (r_kind == lwbkv_pkg::KIND_SET);
                if (!(r_kind == lwbkv_pkg::KIND_SET && r_hit) && !full)
                    r_cnt <= r_cnt + CW'(1);
            end
            // move to front
            if (do_promote) begin
                for (int i = 1; i < ENTRIES; i++)
                    if (IW'(i) <= prom_pos) r_rank[i] <= r_rank[i-1];
                r_rank[0] <= r_rank[prom_pos];
            end
        end
    end

    // assertions
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES)) else $error("entry count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("accept while result held");
    a_wb_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_oact == lwbkv_pkg::ACT_WB) |-> (r_ost == lwbkv_pkg::ST_OK && !r_olast))
        else $error("write-back result malformed");
    a_fetch_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && r_oact == lwbkv_pkg::ACT_FETCH) |-> r_pend)
        else $error("fetch without pending mark");

endmodule
`default_nettype wire

### bench/tb_lru_write_back_kv_cache.sv
// Self-checking bench for the LRU write-back key-value cache.
// Depends on lwbkv_pkg and lru_write_back_kv_cache; a scoreboard class predicts results.
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]  action;
    logic [63:0] out_key;
    logic [63:0] out_value;
    logic [1:0]  status;
    logic        last;
} t_result;

class cache_scoreboard;
    // shadow of the cache contents
    logic [63:0] shadow_keys [16];
    logic [63:0] shadow_vals [16];
    bit          shadow_dirty[16];
    int          lru_order   [16];
    int          live_count;
    bit          waiting_fill;
    logic [63:0] waiting_key;
    int          cap_reg;
    t_result     pending_results[$];
    int          error_count;
    int          result_count;

    function void reset_state();
        for (int i = 0; i < 16; i++) begin
            shadow_dirty[i] = 0;
            lru_order[i] = i;
        end
        live_count = 0;
        waiting_fill = 0;
        waiting_key = '0;
        cap_reg = 16;
    endfunction

    function void queue_result(logic [1:0] act, logic [63:0] k, logic [63:0] v,
                               logic [1:0] st);
        t_result r;
        r.action = act; r.out_key = k; r.out_value = v; r.status = st; r.last = 0;
        pending_results.push_back(r);
    endfunction

    function void to_front(int pos);
        int s;
        s = lru_order[pos];
        for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
        lru_order[0] = s;
    endfunction

    function int lookup(logic [63:0] k);
        for (int p = 0; p < live_count; p++)
            if (shadow_keys[lru_order[p]] == k) return p;
        return -1;
    endfunction

    function void insert(logic [63:0] k, logic [63:0] v, bit d);
        int pos, s, c;
        c = cap_reg < 1 ? 1 : (cap_reg > 16 ? 16 : cap_reg);
        if (live_count >= c) begin
            pos = live_count - 1;
            s = lru_order[pos];
            if (shadow_dirty[s])
                queue_result(lwbkv_pkg::ACT_WB, shadow_keys[s], shadow_vals[s],
                             lwbkv_pkg::ST_OK);
        end else begin
            pos = live_count;
            live_count++;
        end
        s = lru_order[pos];
        to_front(pos);
        shadow_keys[s] = k; shadow_vals[s] = v; shadow_dirty[s] = d;
    endfunction

    // predict the results of one accepted item
    function void note_item(logic [1:0] kind, logic [63:0] k, logic [63:0] v, bit ok);
        int n0, pos, s;
        n0 = pending_results.size();
        if (kind == lwbkv_pkg::KIND_FILL) begin
            if (!waiting_fill) return;
            waiting_fill = 0;
            if (ok) begin
                insert(waiting_key, v, 0);
                queue_result(lwbkv_pkg::ACT_REPLY, waiting_key, v, lwbkv_pkg::ST_OK);
            end else queue_result(lwbkv_pkg::ACT_REPLY, waiting_key, '0, lwbkv_pkg::ST_FAIL);
        end else if (waiting_fill) begin
            queue_result(lwbkv_pkg::ACT_REPLY, k, '0, lwbkv_pkg::ST_BUSY);
        end else if (kind == lwbkv_pkg::KIND_SET) begin
            pos = lookup(k);
            if (pos >= 0) begin
                s = lru_order[pos];
                shadow_vals[s] = v; shadow_dirty[s] = 1;
                to_front(pos);
            end else insert(k, v, 1);
            queue_result(lwbkv_pkg::ACT_REPLY, k, '0, lwbkv_pkg::ST_OK);
        end else if (kind == lwbkv_pkg::KIND_GET) begin
            pos = lookup(k);
            if (pos >= 0) begin
                s = lru_order[pos];
                to_front(pos);
                queue_result(lwbkv_pkg::ACT_REPLY, k, shadow_vals[s], lwbkv_pkg::ST_OK);
            end else begin
                waiting_fill = 1; waiting_key = k;
                queue_result(lwbkv_pkg::ACT_FETCH, k, '0, lwbkv_pkg::ST_OK);
            end
        end else begin
            for (int p = 0; p < live_count; p++) begin
                s = lru_order[p];
                if (shadow_dirty[s]) begin
                    queue_result(lwbkv_pkg::ACT_WB, shadow_keys[s], shadow_vals[s],
                                 lwbkv_pkg::ST_OK);
                    shadow_dirty[s] = 0;
                end
            end
            queue_result(lwbkv_pkg::ACT_REPLY, '0, '0, lwbkv_pkg::ST_OK);
        end
        if (pending_results.size() > n0)
            pending_results[pending_results.size()-1].last = 1;
    endfunction

    function void check_result(t_result got);
        t_result want;
        result_count++;
        if (pending_results.size() == 0) begin
            $error("unexpected result action=%0d key=%h", got.action, got.out_key);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.action != want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action); error_count++;
        end
        if (got.out_key != want.out_key) begin
            $error("out_key: expected %h, got %h", want.out_key, got.out_key); error_count++;
        end
        if (got.out_value != want.out_value) begin
            $error("out_value: expected %h, got %h", want.out_value, got.out_value);
            error_count++;
        end
        if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); error_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); error_count++;
        end
    endfunction
endclass

module tb_lru_write_back_kv_cache;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    wire          s_axis_tready;
    // key[63:0], write_value[127:64], fill_ok[128], zero pad
    logic [135:0] s_axis_tdata = '0;
    // kind[1:0]
    logic [1:0]   s_axis_tuser = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 0;
    // out_key[63:0], out_value[127:64]
    wire  [127:0] m_axis_tdata;
    // action[1:0], status[3:2]
    wire  [3:0]   m_axis_tuser;
    wire          m_axis_tlast;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire  [31:0]  prdata;
    wire          pready;

    cache_scoreboard board;
    int  send_idle_pct, recv_idle_pct;
    bit  recv_hold;
    int  items_sent;
    int  cycles;
    logic [63:0] key_pool[8];

    lru_write_back_kv_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_write_back_kv_cache regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tuser[1:0], m_axis_tdata[63:0], m_axis_tdata[127:64],
                                m_axis_tuser[3:2], m_axis_tlast});
        m_axis_tready <= i_rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        int hold;
        recv_hold = 0;
        wait (items_sent >= 60);
        recv_hold = 1;
        for (hold = 0; hold < 300; hold++) @(posedge i_clk);
        recv_hold = 0;
    end

    // send one item and note it once accepted; valid stays up for the next one
    task automatic send_item(logic [1:0] kind, logic [63:0] k, logic [63:0] v, bit ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'b0, ok, v, k};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(kind, k, v, ok);
        items_sent++;
    endtask

    task automatic write_capacity(int value);
        s_axis_tvalid <= 0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.cap_reg = value & 31;
    endtask

    // mostly keys from a small pool so hits and evictions happen
    function automatic logic [63:0] pick_key();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return key_pool[$urandom_range(7)];
    endfunction

    task automatic random_phase(int count, int cap);
        logic [1:0] kind;
        int r;
        write_capacity(cap);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (board.waiting_fill && r < 85) kind = lwbkv_pkg::KIND_FILL;
            else if (r < 45) kind = lwbkv_pkg::KIND_SET;
            else if (r < 85) kind = lwbkv_pkg::KIND_GET;
            else if (r < 92) kind = lwbkv_pkg::KIND_FLUSH;
            else kind = lwbkv_pkg::KIND_FILL;
            send_item(kind, pick_key(), {$urandom, $urandom}, $urandom_range(3) != 0);
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        cycles = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every kind, busy, stray fill, eviction
        send_item(lwbkv_pkg::KIND_FILL, '0, '1, 1);          // fill with nothing pending
        send_item(lwbkv_pkg::KIND_SET, '0, '1, 0);
        send_item(lwbkv_pkg::KIND_SET, '1, '0, 1);
        send_item(lwbkv_pkg::KIND_GET, '1, '0, 0);
        send_item(lwbkv_pkg::KIND_GET, 64'h5555_aaaa_5555_aaaa, '0, 0);   // miss
        send_item(lwbkv_pkg::KIND_SET, '0, 64'h1, 0);        // busy
        send_item(lwbkv_pkg::KIND_FLUSH, 64'h77, '0, 0);     // busy
        send_item(lwbkv_pkg::KIND_FILL, '0, 64'haaaa_5555_aaaa_5555, 1);
        send_item(lwbkv_pkg::KIND_GET, 64'h1234, '0, 0);
        send_item(lwbkv_pkg::KIND_FILL, '1, '1, 0);          // failed fetch
        send_item(lwbkv_pkg::KIND_FLUSH, '0, '0, 0);
        send_item(lwbkv_pkg::KIND_FLUSH, '0, '0, 0);         // nothing dirty
        write_capacity(0);                                   // acts as one entry
        send_item(lwbkv_pkg::KIND_SET, 64'h10, 64'h20, 0);   // count above capacity: evict
        send_item(lwbkv_pkg::KIND_SET, 64'h11, 64'h21, 0);
        send_item(lwbkv_pkg::KIND_GET, 64'h10, '0, 0);
        send_item(lwbkv_pkg::KIND_FILL, '0, 64'h30, 1);
        write_capacity(31);                                  // acts as sixteen
        for (int i = 0; i < 5; i++)
            send_item(lwbkv_pkg::KIND_SET, 64'h100 + i, 64'h200 + i, 0);

        send_idle_pct = 37; recv_idle_pct = 79;
        random_phase(70, 3);
        send_idle_pct = 79; recv_idle_pct = 37;
        random_phase(70, 16);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(40, 1);
        random_phase(40, 7);

        s_axis_tvalid <= 0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d items and %0d results over capacities 1..16, with stalls",
                 items_sent, board.result_count);
        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("lru_write_back_kv_cache regression: pass");
        else
            $display("lru_write_back_kv_cache regression: fail");
        $finish;
    end
endmodule
